FILE: src/cfr_pkg.sv
// Shared constants, types and the CRC-8 byte function of the frame receiver.
package cfr_pkg;

    localparam int FRAME_BYTES_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int REG_CRC_POLY    = 0;

    localparam logic [7:0] START_MARK = 8'hEE;
    localparam logic [7:0] POLY_RESET = 8'h8C;

    typedef struct packed {
        logic crc_ok;
    } t_frame_desc;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        logic [7:0] d;
        logic       out_bit;
        c = crc;
        d = data;
        for (int i = 0; i < 8; i++) begin
            out_bit = c[0] ^ d[0];
            c = {1'b0, c[7:1]};
            if (out_bit) begin
                c = c ^ poly;
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

FILE: src/cfr_if.sv
// Valid/ready channel interfaces for received bytes and payload words.
interface cfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       crc_ok;
    logic       last;

    modport source (output valid, output payload_byte, output crc_ok, output last, input ready);
    modport sink (input valid, input payload_byte, input crc_ok, input last, output ready);
endinterface

FILE: src/cfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/cfr_front.sv
// Front end: frames received bytes, stores the payload and runs the CRC.
module cfr_front #(
    parameter int FRAME_BYTES = cfr_pkg::FRAME_BYTES_DEF,
    localparam int AW         = $clog2(2 * FRAME_BYTES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cfr_rx_if.sink               i_rx,
    input  logic [7:0]           i_poly,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output cfr_pkg::t_frame_desc o_push_desc,
    output logic                 o_wr_en,
    output logic [AW-1:0]        o_wr_addr,
    output logic [7:0]           o_wr_data
);
    import cfr_pkg::*;

    localparam int FRAME_TOTAL = FRAME_BYTES + 3;
    localparam int PW          = $clog2(FRAME_TOTAL);

    localparam logic [PW-1:0] POS_START = PW'(0);
    localparam logic [PW-1:0] POS_CRC   = PW'(1);
    localparam logic [PW-1:0] POS_LAST  = PW'(FRAME_BYTES + 2);

    logic [PW-1:0] r_pos, n_pos;
    logic          r_start_valid, n_start_valid;
    logic [7:0]    r_rx_crc, n_rx_crc;
    logic [7:0]    r_crc, n_crc;
    logic          r_bank, n_bank;
    logic          accept;
    logic [PW-1:0] pay_idx;

    assign i_rx.ready = !i_queue_full;
    assign accept     = i_rx.valid && i_rx.ready;
    assign pay_idx    = r_pos - PW'(2);

    always_comb begin
        n_pos         = r_pos;
        n_start_valid = r_start_valid;
        n_rx_crc      = r_rx_crc;
        n_crc         = r_crc;
        n_bank        = r_bank;
        o_wr_en       = 1'b0;
        o_push        = 1'b0;
        if (accept) begin
            if (r_pos == POS_START) begin
                n_start_valid = (i_rx.rx_byte == START_MARK);
                n_crc         = 8'h00;
                n_pos         = r_pos + PW'(1);
            end else if (r_pos == POS_CRC) begin
                n_rx_crc = i_rx.rx_byte;
                n_pos    = r_pos + PW'(1);
            end else if (r_pos != POS_LAST) begin
                o_wr_en = 1'b1;
                n_crc   = crc8_byte(r_crc, i_rx.rx_byte, i_poly);
                n_pos   = r_pos + PW'(1);
            end else begin
                o_push = r_start_valid;
                if (r_start_valid) begin
                    n_bank = !r_bank;
                end
                n_pos = POS_START;
            end
        end
    end

    assign o_push_desc.crc_ok = (r_rx_crc == r_crc);
    assign o_wr_data          = i_rx.rx_byte;
    assign o_wr_addr          = r_bank ? (AW'(FRAME_BYTES) + AW'(pay_idx)) : AW'(pay_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= POS_START;
            r_start_valid <= 1'b0;
            r_rx_crc      <= 8'h00;
            r_crc         <= 8'h00;
            r_bank        <= 1'b0;
        end else begin
            r_pos         <= n_pos;
            r_start_valid <= n_start_valid;
            r_rx_crc      <= n_rx_crc;
            r_crc         <= n_crc;
            r_bank        <= n_bank;
        end
    end

endmodule

FILE: src/cfr_queue.sv
// Short queue of completed frame descriptors between front and back end.
module cfr_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cfr_pkg::t_frame_desc i_push_desc,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_nonempty,
    output cfr_pkg::t_frame_desc o_head
);
    import cfr_pkg::*;

    localparam int PTRW = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);

    t_frame_desc     r_entry [QUEUE_DEPTH];
    logic [PTRW-1:0] r_wr_ptr;
    logic [PTRW-1:0] r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full     = (r_count == CW'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != CW'(0));
    assign o_head     = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTRW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTRW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: src/cfr_back.sv
// Back end: reads a stored frame from RAM and sends its payload words.
module cfr_back #(
    parameter int FRAME_BYTES = cfr_pkg::FRAME_BYTES_DEF,
    localparam int AW         = $clog2(2 * FRAME_BYTES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_desc_valid,
    input  cfr_pkg::t_frame_desc i_desc,
    output logic                 o_pop,
    output logic                 o_rd_en,
    output logic [AW-1:0]        o_rd_addr,
    input  logic [7:0]           i_rd_data,
    cfr_out_if.source            o_out
);
    import cfr_pkg::*;

    localparam int IW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SHOW = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_bank, n_bank;
    logic [7:0]    r_byte, n_byte;
    logic          r_ok, n_ok;
    logic          r_last, n_last;
    logic [IW-1:0] rd_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_bank  = r_bank;
        n_byte  = r_byte;
        n_ok    = r_ok;
        n_last  = r_last;
        rd_idx  = r_idx;
        o_rd_en = 1'b0;
        o_pop   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_desc_valid) begin
                    o_rd_en = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_byte  = i_rd_data;
                n_ok    = i_desc.crc_ok;
                n_last  = (r_idx == IW'(FRAME_BYTES - 1));
                n_state = S_SHOW;
            end
            S_SHOW: begin
                if (o_out.ready) begin
                    if (r_last) begin
                        o_pop   = 1'b1;
                        n_idx   = '0;
                        n_bank  = !r_bank;
                        n_state = S_IDLE;
                    end else begin
                        rd_idx  = r_idx + IW'(1);
                        n_idx   = rd_idx;
                        o_rd_en = 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rd_addr          = r_bank ? (AW'(FRAME_BYTES) + AW'(rd_idx)) : AW'(rd_idx);
    assign o_out.valid        = (r_state == S_SHOW);
    assign o_out.payload_byte = r_byte;
    assign o_out.crc_ok       = r_ok;
    assign o_out.last         = r_last;

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_ok   <= n_ok;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_bank  <= n_bank;
        end
    end

endmodule

FILE: src/crc8_checked_frame_receiver_top.sv
// Top level of the CRC-8 checked frame receiver with its register port.
//
//   Channel   Dir   Word                              Handshake
//   i_rx      in    rx_byte                           valid/ready
//   o_out     out   payload_byte, crc_ok, last        valid/ready
//   APB       in    crc_polynomial at byte address 0  psel/penable/pready
//
// The front end takes one byte per cycle; it stalls only while two completed
// frames wait in the queue, since the payload RAM holds two frame banks.
// In the back end each payload word passes a RAM read state, then an output
// register state; the next word is read only once the current one is taken,
// and each frame starts from the idle state.
// Reset is synchronous and needs no clearing pass; the RAM is never read
// before it is written. A stalled output holds its word.
module crc8_checked_frame_receiver_top #(
    parameter int FRAME_BYTES = cfr_pkg::FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfr_rx_if.sink      i_rx,
    cfr_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cfr_pkg::*;

    localparam int AW = $clog2(2 * FRAME_BYTES);

    logic          poly_wr_en;
    logic [7:0]    r_crc_poly;
    logic          reg_hit;
    logic          push;
    t_frame_desc   push_desc;
    logic          pop;
    logic          queue_full;
    logic          desc_valid;
    t_frame_desc   head_desc;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign pready     = 1'b1;
    assign reg_hit    = (paddr[2] == 1'(REG_CRC_POLY));
    assign poly_wr_en = psel && penable && pwrite && pready && reg_hit;
    assign prdata     = reg_hit ? {24'h000000, r_crc_poly} : 32'h00000000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_poly <= POLY_RESET;
        end else if (poly_wr_en) begin
            r_crc_poly <= pwdata[7:0];
        end
    end

    cfr_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .i_poly      (r_crc_poly),
        .i_queue_full(queue_full),
        .o_push      (push),
        .o_push_desc (push_desc),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    cfr_ram #(
        .WIDTH(8),
        .DEPTH(2 * FRAME_BYTES)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    cfr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_desc(push_desc),
        .i_pop      (pop),
        .o_full     (queue_full),
        .o_nonempty (desc_valid),
        .o_head     (head_desc)
    );

    cfr_back #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_desc_valid(desc_valid),
        .i_desc      (head_desc),
        .o_pop       (pop),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_out       (o_out)
    );

endmodule
